FILE: rtl/core/lcfe_pkg.sv
`default_nettype none
package lcfe_pkg;

  // width of the payload length counter
  localparam int LENGTH_BITS = 16;

  // wire characters
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_A    = 8'h61;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NUL  = 8'h00;

  // lengths below this go out as one byte
  localparam logic [15:0] SHORT_LIMIT = 16'd256;

  // one byte of the framed stream
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_last;
  } out_beat_t;

  // power of ten for a decimal position (0 = units, 4 = ten thousands)
  function automatic logic [16:0] dec_pow(input logic [2:0] pos);
    logic [16:0] p;
    unique case (pos)
      3'd0:    p = 17'd1;
      3'd1:    p = 17'd10;
      3'd2:    p = 17'd100;
      3'd3:    p = 17'd1000;
      3'd4:    p = 17'd10000;
      default: p = 17'd0;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/length_checksum_frame_encoder_core.sv
// A byte is held in the lcfe_seq item slot and then in the output register.
// Throughput: one payload byte per cycle while out_ready holds; the output
// register sends one wire byte per transfer, so a frame's first byte also sends
// E, A, E, a length byte or NUL, digits, NUL (from 256); a last byte adds the sum.
// Reset (rst, synchronous): drops the held item and output byte, closes the frame.
`default_nettype none
module length_checksum_frame_encoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        first_byte,
  input  wire logic [15:0] payload_length,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [7:0]  out_byte,
  output logic             run_last,
  output logic             frame_last
);
  import lcfe_pkg::*;

  logic      emit_valid;
  logic      emit_ready;
  out_beat_t emit_beat;
  out_beat_t out_beat;

  lcfe_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .first_byte     (first_byte),
    .payload_length (payload_length),
    .emit_valid     (emit_valid),
    .emit_ready     (emit_ready),
    .emit_beat      (emit_beat)
  );

  lcfe_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .emit_valid (emit_valid),
    .emit_ready (emit_ready),
    .emit_beat  (emit_beat),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_beat   (out_beat)
  );

  assign out_byte   = out_beat.out_byte;
  assign run_last   = out_beat.run_last;
  assign frame_last = out_beat.frame_last;

endmodule
`default_nettype wire

FILE: rtl/core/lcfe_digit.sv
`default_nettype none
module lcfe_digit (
  input  wire logic [15:0] val,
  input  wire logic [2:0]  pos,
  output logic      [3:0]  digit,
  output logic      [15:0] rem
);
  import lcfe_pkg::*;

  logic [16:0] pow;
  logic [16:0] val_x;
  logic [16:0] mult [1:9];
  logic [9:1]  ge;
  logic [16:0] sub;

  // compare against all nine multiples of the current power in parallel
  always_comb begin
    pow   = dec_pow(pos);
    val_x = {1'b0, val};
    for (int k = 1; k <= 9; k++) begin
      mult[k] = 17'(pow * 17'(k));
      ge[k]   = (val_x >= mult[k]);
    end
  end

  // the compares are monotone: the digit is how many of them pass
  always_comb begin
    digit = 4'd0;
    sub   = 17'd0;
    for (int k = 1; k <= 9; k++) begin
      if (ge[k]) begin
        digit = 4'(k);
        sub   = mult[k];
      end
    end
    rem = 16'(val_x - sub);
  end

endmodule
`default_nettype wire

FILE: rtl/core/lcfe_seq.sv
`default_nettype none
module lcfe_seq (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          data_byte,
  input  wire logic                first_byte,
  input  wire logic [15:0]         payload_length,
  output logic                     emit_valid,
  input  wire logic                emit_ready,
  output lcfe_pkg::out_beat_t      emit_beat
);
  import lcfe_pkg::*;

  // byte phases of one item
  localparam logic [2:0] P_E0   = 3'd0;
  localparam logic [2:0] P_A    = 3'd1;
  localparam logic [2:0] P_E1   = 3'd2;
  localparam logic [2:0] P_LEN  = 3'd3;
  localparam logic [2:0] P_DIG  = 3'd4;
  localparam logic [2:0] P_Z    = 3'd5;
  localparam logic [2:0] P_DATA = 3'd6;
  localparam logic [2:0] P_SUM  = 3'd7;

  // held item
  logic             slot_valid;
  logic [7:0]       slot_data;
  logic [15:0]      slot_len;

  // sequencer and frame state
  logic [2:0]             phase, phase_next;
  logic [15:0]            dig_val;
  logic [2:0]             dig_pos;
  logic [LENGTH_BITS-1:0] bytes_remaining;
  logic [7:0]             running_sum;
  logic                   frame_open;

  logic [LENGTH_BITS-1:0] plen;
  logic [LENGTH_BITS-1:0] eff_len;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic [15:0]            len16;
  logic                   is_short;
  logic [2:0]             start_pos;
  logic [3:0]             digit;
  logic [15:0]            dig_rem;
  logic                   drop;
  logic                   item_end;
  logic                   fire;
  logic                   slot_done;

  lcfe_digit u_digit (
    .val   (dig_val),
    .pos   (dig_pos),
    .digit (digit),
    .rem   (dig_rem)
  );

  // length decode; a zero length counts as one
  always_comb begin
    plen      = LENGTH_BITS'(slot_len);
    eff_len   = (plen == '0) ? LENGTH_BITS'(1) : plen;
    len16     = 16'(eff_len);
    is_short  = (len16 < SHORT_LIMIT);
    rem_dec   = bytes_remaining - LENGTH_BITS'(1);
    if (len16 >= 16'd10000) begin
      start_pos = 3'd4;
    end else if (len16 >= 16'd1000) begin
      start_pos = 3'd3;
    end else begin
      start_pos = 3'd2;
    end
  end

  // byte selection for the current phase
  always_comb begin
    emit_valid           = slot_valid;
    emit_beat.out_byte   = CH_NUL;
    emit_beat.run_last   = 1'b0;
    emit_beat.frame_last = 1'b0;
    phase_next           = phase;
    drop                 = 1'b0;
    item_end             = 1'b0;
    unique case (phase)
      P_E0: begin
        emit_beat.out_byte = CH_E;
        phase_next         = P_A;
      end
      P_A: begin
        emit_beat.out_byte = CH_A;
        phase_next         = P_E1;
      end
      P_E1: begin
        emit_beat.out_byte = CH_E;
        phase_next         = P_LEN;
      end
      P_LEN: begin
        emit_beat.out_byte = is_short ? len16[7:0] : CH_NUL;
        phase_next         = is_short ? P_DATA : P_DIG;
      end
      P_DIG: begin
        emit_beat.out_byte = CH_ZERO + {4'd0, digit};
        phase_next         = (dig_pos == 3'd0) ? P_Z : P_DIG;
      end
      P_Z: begin
        emit_beat.out_byte = CH_NUL;
        phase_next         = P_DATA;
      end
      P_DATA: begin
        emit_beat.out_byte = slot_data;
        if (!frame_open) begin
          // stray byte outside a frame
          drop       = slot_valid;
          emit_valid = 1'b0;
        end else if (rem_dec != '0) begin
          emit_beat.run_last = 1'b1;
          item_end           = 1'b1;
        end else begin
          phase_next = P_SUM;
        end
      end
      P_SUM: begin
        emit_beat.out_byte   = running_sum;
        emit_beat.run_last   = 1'b1;
        emit_beat.frame_last = 1'b1;
        item_end             = 1'b1;
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  assign fire      = emit_valid && emit_ready;
  assign slot_done = slot_valid && (drop || (fire && item_end));
  assign in_ready  = !slot_valid || slot_done;

  // item slot and phase
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
      phase      <= P_E0;
    end else if (in_valid && in_ready) begin
      slot_valid <= 1'b1;
      phase      <= first_byte ? P_E0 : P_DATA;
    end else if (slot_done) begin
      slot_valid <= 1'b0;
    end else if (fire) begin
      phase <= phase_next;
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      slot_data <= data_byte;
      slot_len  <= payload_length;
    end
  end

  // frame state, updated on each byte transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
      running_sum     <= 8'd0;
      frame_open      <= 1'b0;
    end else if (fire) begin
      unique case (phase)
        P_E0: begin
          frame_open      <= 1'b1;
          bytes_remaining <= eff_len;
          running_sum     <= CH_E;
        end
        P_DATA: begin
          bytes_remaining <= rem_dec;
          running_sum     <= running_sum + emit_beat.out_byte;
        end
        P_SUM: begin
          frame_open  <= 1'b0;
          running_sum <= 8'd0;
        end
        default: begin
          running_sum <= running_sum + emit_beat.out_byte;
        end
      endcase
    end
  end

  // decimal digit walk
  always_ff @(posedge clk) begin
    if (fire && phase == P_LEN) begin
      dig_val <= len16;
      dig_pos <= start_pos;
    end else if (fire && phase == P_DIG) begin
      dig_val <= dig_rem;
      dig_pos <= dig_pos - 3'd1;
    end
  end

  // checks
  a_check_ends_item: assert property (@(posedge clk) disable iff (rst)
    (fire && emit_beat.frame_last) |-> (emit_beat.run_last && slot_done))
    else $error("checksum byte does not end its item");

  a_sum_in_frame: assert property (@(posedge clk) disable iff (rst)
    (slot_valid && phase == P_SUM) |-> frame_open)
    else $error("checksum phase with no open frame");

  a_digit_pos: assert property (@(posedge clk) disable iff (rst)
    (slot_valid && phase == P_DIG) |-> (dig_pos <= 3'd4))
    else $error("decimal position out of range");

  a_digit_walk: assert property (@(posedge clk) disable iff (rst)
    (fire && phase == P_DIG && dig_pos == 3'd0) |=> (phase == P_Z))
    else $error("units digit not followed by trailing zero");

endmodule
`default_nettype wire

FILE: rtl/core/lcfe_out_reg.sv
`default_nettype none
module lcfe_out_reg (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                emit_valid,
  output logic                     emit_ready,
  input  wire lcfe_pkg::out_beat_t emit_beat,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lcfe_pkg::out_beat_t      out_beat
);
  import lcfe_pkg::*;

  // take a new byte when empty or when the held one leaves this cycle
  assign emit_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_ready) begin
      out_valid <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ready && emit_valid) begin
      out_beat <= emit_beat;
    end
  end

endmodule
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import lcfe_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int HOLD_CYCLES     = 300;
  localparam int HOLD_AFTER      = 60;
  localparam int TAIL_CYCLES     = 20;
  localparam int RANDOM_ITEMS    = 150;
  localparam int MAX_GAP         = 18;
  localparam int unsigned LEN_MASK =
    (LENGTH_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << LENGTH_BITS) - 1);

  // one pending input transfer; sync makes the sender drain the block first
  typedef struct {
    logic [7:0]  data;
    logic        first;
    logic [15:0] len;
    bit          sync;
  } src_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        first_byte = 1'b0;
  logic [15:0] payload_length = 16'h0000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        run_last;
  logic        frame_last;

  length_checksum_frame_encoder_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .first_byte     (first_byte),
    .payload_length (payload_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .run_last       (run_last),
    .frame_last     (frame_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  src_item_t pending_items[$];
  out_beat_t wire_bytes_due[$];
  out_beat_t item_beats[$];

  // encoder shadow state
  logic [LENGTH_BITS-1:0] enc_remaining = '0;
  logic [7:0]             enc_sum = 8'h00;
  logic                   enc_open = 1'b0;

  logic in_took = 1'b0;
  logic out_took = 1'b0;
  int   errors = 0;
  int   bytes_seen = 0;
  int   idle_cycles = 0;

  // stimulus generator bookkeeping
  bit          gen_open = 0;
  int unsigned gen_left = 0;
  int          items_made = 0;
  bit          sync_next = 0;

  // appends one wire byte to the bytes caused by the current item
  function automatic void emit_wire_byte(input logic [7:0] b, input logic chk);
    out_beat_t bt;
    bt.out_byte   = b;
    bt.run_last   = 1'b0;
    bt.frame_last = chk;
    item_beats.push_back(bt);
    if (!chk) enc_sum = enc_sum + b;
  endfunction

  // works out the wire bytes that one accepted input transfer produces
  function automatic void encode_item(input logic [7:0] d, input logic f,
                                      input logic [15:0] l);
    int unsigned plen;
    int unsigned v;
    logic [7:0]  digits[$];
    out_beat_t   tail;
    item_beats.delete();
    // stray byte outside a frame is dropped
    if (!f && !enc_open) return;
    if (f) begin
      plen = l & LEN_MASK;
      if (plen == 0) plen = 1;
      enc_sum       = 8'h00;
      enc_open      = 1'b1;
      enc_remaining = LENGTH_BITS'(plen);
      emit_wire_byte(CH_E, 1'b0);
      emit_wire_byte(CH_A, 1'b0);
      emit_wire_byte(CH_E, 1'b0);
      if (plen < SHORT_LIMIT) begin
        emit_wire_byte(plen[7:0], 1'b0);
      end else begin
        v = plen;
        while (v != 0) begin
          digits.push_front(CH_ZERO + 8'(v % 10));
          v = v / 10;
        end
        emit_wire_byte(CH_NUL, 1'b0);
        foreach (digits[i]) emit_wire_byte(digits[i], 1'b0);
        emit_wire_byte(CH_NUL, 1'b0);
      end
    end
    emit_wire_byte(d, 1'b0);
    enc_remaining = enc_remaining - 1'b1;
    if (enc_remaining == '0) begin
      emit_wire_byte(enc_sum, 1'b1);
      enc_open = 1'b0;
      enc_sum  = 8'h00;
    end
    tail = item_beats.pop_back();
    tail.run_last = 1'b1;
    item_beats.push_back(tail);
    foreach (item_beats[i]) wire_bytes_due.push_back(item_beats[i]);
  endfunction

  // per-item idle draw; calm stretches send back to back
  function automatic int draw_gap(input bit calm);
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  task automatic add_item(input logic [7:0] d, input logic f, input logic [15:0] l);
    src_item_t it;
    int unsigned eff;
    it.data  = d;
    it.first = f;
    it.len   = l;
    it.sync  = sync_next;
    sync_next = 0;
    pending_items.push_back(it);
    if (f) begin
      eff = l & LEN_MASK;
      gen_open = 1;
      gen_left = (eff == 0) ? 1 : eff;
      items_made++;
    end else if (gen_open) begin
      gen_left--;
      if (gen_left == 0) gen_open = 0;
      items_made++;
    end
  endtask

  // header with the given length, then nbytes - 1 more payload bytes
  task automatic add_frame(input logic [15:0] l, input int nbytes);
    add_item(8'($urandom), 1'b1, l);
    for (int i = 1; i < nbytes; i++) add_item(8'($urandom), 1'b0, 16'($urandom));
  endtask

  // sender: offers items from the pending queue at the falling edge
  int  src_gap = 0;
  bit  src_calm = 0;
  always @(negedge clk) begin
    logic      vld;
    src_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
      src_gap = 0;
    end else begin
      vld = in_valid;
      if (in_took) begin
        vld = 1'b0;
        if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
        src_gap = draw_gap(src_calm);
      end
      if (!vld) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_items.size() != 0) begin
          if (!pending_items[0].sync || wire_bytes_due.size() == 0) begin
            it = pending_items.pop_front();
            data_byte      <= it.data;
            first_byte     <= it.first;
            payload_length <= it.len;
            vld = 1'b1;
          end
        end
      end
      in_valid <= vld;
    end
  end

  // receiver: per-transfer stalls plus one long hold-off
  int  rx_gap = 0;
  int  rx_hold = 0;
  bit  rx_hold_done = 0;
  bit  rx_calm = 0;
  always @(negedge clk) begin
    logic rdy;
    if (rst) begin
      out_ready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_took) begin
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        rx_gap = draw_gap(rx_calm);
      end
      if (!rx_hold_done && bytes_seen >= HOLD_AFTER) begin
        rx_hold_done = 1;
        rx_hold = HOLD_CYCLES;
      end
      rdy = 1'b1;
      if (rx_hold > 0) begin
        rx_hold--;
        rdy = 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        rdy = 1'b0;
      end
      out_ready <= rdy;
    end
  end

  // monitor: predicts on input transfers, checks output transfers
  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      in_took  <= 1'b0;
      out_took <= 1'b0;
      enc_remaining = '0;
      enc_sum = 8'h00;
      enc_open = 1'b0;
      idle_cycles = 0;
    end else begin
      in_took  <= in_valid && in_ready;
      out_took <= out_valid && out_ready;
      if (in_valid && in_ready) encode_item(data_byte, first_byte, payload_length);
      if (out_valid && out_ready) begin
        bytes_seen++;
        if (wire_bytes_due.size() == 0) begin
          $display("%0t: unexpected byte, expected none, got %h", $time, out_byte);
          errors++;
        end else begin
          want = wire_bytes_due.pop_front();
          if (out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %h, got %h", $time, want.out_byte, out_byte);
            errors++;
          end
          if (run_last !== want.run_last) begin
            $display("%0t: run_last expected %b, got %b", $time, want.run_last, run_last);
            errors++;
          end
          if (frame_last !== want.frame_last) begin
            $display("%0t: frame_last expected %b, got %b", $time, want.frame_last,
                     frame_last);
            errors++;
          end
        end
      end
      // watchdog on cycles without any transfer
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int r;
    int n;
    // directed: stray byte right after reset
    add_item(8'hA5, 1'b0, 16'hFFFF);
    // one-byte frames, zero length taken as one
    add_item(8'h00, 1'b1, 16'd1);
    add_item(8'hFF, 1'b1, 16'd0);
    // short frame with extreme data
    add_item(8'hFF, 1'b1, 16'd3);
    add_item(8'h00, 1'b0, 16'h0000);
    add_item(8'h80, 1'b0, 16'hFFFF);
    // stray between frames
    add_item(8'h5A, 1'b0, 16'h1234);
    // headers cut short by a restart, covering the length forms
    add_frame(16'd255, 3);
    add_frame(16'd256, 2);
    add_frame(16'd65535, 2);
    add_frame(16'd10000, 1);
    add_frame(16'd9999, 1);
    add_frame(16'd1000, 1);
    add_frame(16'hAAAA, 1);
    add_frame(16'h5555, 1);
    // closing frame that completes
    add_frame(16'd2, 2);

    // random part: mostly complete frames with random content
    sync_next = 1;
    items_made = 0;
    while (items_made < RANDOM_ITEMS) begin
      if (items_made >= RANDOM_ITEMS / 2 && items_made < RANDOM_ITEMS / 2 + 10) sync_next = 1;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        n = $urandom_range(1, 16);
        if ($urandom_range(0, 7) == 0) add_frame(16'd0, 1);
        else add_frame(16'(n), n);
        if ($urandom_range(0, 4) == 0) add_item(8'($urandom), 1'b0, 16'($urandom));
      end else if (r < 85) begin
        add_frame(16'($urandom), $urandom_range(1, 3));
      end else if (r < 95) begin
        add_frame(16'($urandom_range(4, 255)), $urandom_range(1, 2));
      end else begin
        add_item(8'($urandom), 1'b0, 16'($urandom));
      end
    end
    // closing one-byte frame
    add_frame(16'd1, 1);

    // wait for all transfers and results, then a short tail
    do @(posedge clk); while (pending_items.size() != 0 || in_valid);
    while (wire_bytes_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hold reset from the start, then release it on a falling clock edge
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

endmodule
